// ----- rtl/cnma_pkg.sv -----
// cone neighbor mass accumulator package: item structs, widths, register indexes
// no dependencies; imported by cone_neighbor_mass_accumulator
package cnma_pkg;

  localparam int COORD_BITS = 24;
  localparam int MASS_BITS  = 32;

  localparam int COUNT_W = 16;
  localparam int TOTAL_W = 48;
  localparam int COS_W   = 17;
  localparam int AXES_W  = 3;
  localparam int BOX_W   = COORD_BITS + 1;
  localparam int CFG_W   = (BOX_W > COS_W) ? BOX_W : COS_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_BOX_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COS_SQ   = 3'd4;

  localparam logic [BOX_W-1:0]  BOX_RESET  = {1'b1, {COORD_BITS{1'b0}}};
  localparam logic [AXES_W-1:0] AXES_RESET = 3'b111;
  localparam logic [COS_W-1:0]  COS_RESET  = 17'd63560;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] MASS_MAX  = {TOTAL_W{1'b1}};

  typedef struct packed {
    logic [COORD_BITS-1:0] target_x;
    logic [COORD_BITS-1:0] target_y;
    logic [COORD_BITS-1:0] target_z;
    logic [COORD_BITS-1:0] search_radius;
    logic [COORD_BITS-1:0] nbr_x;
    logic [COORD_BITS-1:0] nbr_y;
    logic [COORD_BITS-1:0] nbr_z;
    logic [MASS_BITS-1:0]  nbr_mass;
    logic                  last_nbr;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] neighbor_count;
    logic [TOTAL_W-1:0] cone_mass;
    logic               saturated;
  } out_item_t;

endpackage

// ----- rtl/cone_neighbor_mass_accumulator.sv -----
// cone neighbor mass accumulator: sphere count and double-cone mass per target
// one shared signed multiplier under a step sequencer; depends on cnma_pkg
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | cnma_pkg::in_item_t
//   out_    | output    | out_valid / out_stall | cnma_pkg::out_item_t
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata
//
// each candidate makes six passes through the one multiplier (radius, three
// offsets, two halves of the cone product) plus offset sum, compare and total
// update steps
// a last candidate waits in the update step while the output register is full and stalled
// in_stall is high from transfer until the update step is done
// rst_n is synchronous; no clearing pass is needed
module cone_neighbor_mass_accumulator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cnma_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cnma_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [cnma_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cnma_pkg::CFG_W-1:0]     cfg_wdata
);
  import cnma_pkg::*;

  localparam int OFS_W  = COORD_BITS + 3;
  localparam int SQ_W   = 2 * COORD_BITS + 3;
  localparam int R2_W   = 2 * COORD_BITS + 4;
  localparam int H2_W   = 2 * COORD_BITS;
  localparam int LO_W   = COORD_BITS + 2;
  localparam int MUL_W  = (COORD_BITS + 3 > COS_W + 1) ? COORD_BITS + 3 : COS_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int CMP_W  = COS_W + R2_W;
  localparam int CONE_SHIFT = 16;

  typedef enum logic [3:0] {
    S_IDLE, S_RAD, S_DX, S_DY, S_DZ, S_SUM, S_CLO, S_CHI, S_CMP, S_FIN
  } state_t;

  function automatic logic signed [OFS_W-1:0] wrap_ofs(
    input logic [COORD_BITS-1:0] t,
    input logic [COORD_BITS-1:0] n,
    input logic [BOX_W-1:0]      box,
    input logic                  en
  );
    logic signed [OFS_W-1:0] d;
    logic signed [OFS_W-1:0] b;
    logic signed [OFS_W-1:0] h;
    d = signed'(OFS_W'(t)) - signed'(OFS_W'(n));
    b = signed'(OFS_W'(box));
    h = signed'(OFS_W'(box >> 1));
    if (en) begin
      if (d > h) begin
        d = d - b;
      end
      if (d < -h) begin
        d = d + b;
      end
    end
    return d;
  endfunction

  state_t state_r;

  logic [BOX_W-1:0]  box_x_r, box_y_r, box_z_r;
  logic [AXES_W-1:0] axes_r;
  logic [COS_W-1:0]  cos_sq_r;

  in_item_t                item_r;
  logic signed [OFS_W-1:0] dx_r, dy_r, dz_r;
  logic [PROD_W-1:0]       prod_r;
  logic [H2_W-1:0]         h2_r;
  logic [R2_W-1:0]         r2_r;
  logic [SQ_W-1:0]         dz2_r;
  logic [PROD_W-1:0]       cone_lo_r;
  logic                    in_sphere_r;
  logic                    cone_hit_r;

  logic [COUNT_W-1:0] count_total_r;
  logic [TOTAL_W-1:0] mass_total_r;
  logic               sat_r;

  logic                out_valid_r;
  out_item_t           out_data_r;

  logic signed [MUL_W-1:0]  op_a, op_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [CMP_W-1:0]         cone_lhs, cone_rhs;

  logic [COUNT_W-1:0] count_nxt;
  logic [TOTAL_W-1:0] mass_nxt;
  logic               sat_nxt;
  logic [TOTAL_W:0]   mass_sum;
  logic               in_xfer;
  logic               fin_go;
  logic               out_load;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign fin_go    = !item_r.last_nbr || !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_FIN) && fin_go && item_r.last_nbr;

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_RAD: begin
        op_a = signed'(MUL_W'(item_r.search_radius));
        op_b = signed'(MUL_W'(item_r.search_radius));
      end
      S_DX: begin
        op_a = MUL_W'(dx_r);
        op_b = MUL_W'(dx_r);
      end
      S_DY: begin
        op_a = MUL_W'(dy_r);
        op_b = MUL_W'(dy_r);
      end
      S_DZ: begin
        op_a = MUL_W'(dz_r);
        op_b = MUL_W'(dz_r);
      end
      S_CLO: begin
        op_a = signed'(MUL_W'(cos_sq_r));
        op_b = signed'(MUL_W'(r2_r[LO_W-1:0]));
      end
      S_CHI: begin
        op_a = signed'(MUL_W'(cos_sq_r));
        op_b = signed'(MUL_W'(r2_r[R2_W-1:LO_W]));
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_p    = op_a * op_b;
  assign cone_lhs = CMP_W'(dz2_r) << CONE_SHIFT;
  assign cone_rhs = CMP_W'(cone_lo_r) + (CMP_W'(prod_r) << LO_W);

  // running totals with saturation
  always_comb begin
    count_nxt = count_total_r;
    mass_nxt  = mass_total_r;
    sat_nxt   = sat_r;
    mass_sum  = {1'b0, mass_total_r} + (TOTAL_W + 1)'(item_r.nbr_mass);
    if (in_sphere_r) begin
      if (count_total_r == COUNT_MAX) begin
        sat_nxt = 1'b1;
      end else begin
        count_nxt = count_total_r + COUNT_W'(1);
      end
    end
    if (cone_hit_r) begin
      if (mass_sum[TOTAL_W]) begin
        mass_nxt = MASS_MAX;
        sat_nxt  = 1'b1;
      end else begin
        mass_nxt = mass_sum[TOTAL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      box_x_r       <= BOX_RESET;
      box_y_r       <= BOX_RESET;
      box_z_r       <= BOX_RESET;
      axes_r        <= AXES_RESET;
      cos_sq_r      <= COS_RESET;
      count_total_r <= '0;
      mass_total_r  <= '0;
      sat_r         <= 1'b0;
      out_valid_r   <= 1'b0;
      in_sphere_r   <= 1'b0;
      cone_hit_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BOX_X:    box_x_r  <= cfg_wdata[BOX_W-1:0];
          CFG_BOX_Y:    box_y_r  <= cfg_wdata[BOX_W-1:0];
          CFG_BOX_Z:    box_z_r  <= cfg_wdata[BOX_W-1:0];
          CFG_PERIODIC: axes_r   <= cfg_wdata[AXES_W-1:0];
          CFG_COS_SQ:   cos_sq_r <= cfg_wdata[COS_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            item_r  <= in_data;
            state_r <= S_RAD;
          end
        end
        S_RAD: begin
          dx_r    <= wrap_ofs(item_r.target_x, item_r.nbr_x, box_x_r, axes_r[0]);
          dy_r    <= wrap_ofs(item_r.target_y, item_r.nbr_y, box_y_r, axes_r[1]);
          dz_r    <= wrap_ofs(item_r.target_z, item_r.nbr_z, box_z_r, axes_r[2]);
          prod_r  <= unsigned'(mul_p);
          state_r <= S_DX;
        end
        S_DX: begin
          h2_r    <= prod_r[H2_W-1:0];
          prod_r  <= unsigned'(mul_p);
          state_r <= S_DY;
        end
        S_DY: begin
          r2_r    <= R2_W'(prod_r[SQ_W-1:0]);
          prod_r  <= unsigned'(mul_p);
          state_r <= S_DZ;
        end
        S_DZ: begin
          r2_r    <= r2_r + R2_W'(prod_r[SQ_W-1:0]);
          prod_r  <= unsigned'(mul_p);
          state_r <= S_SUM;
        end
        S_SUM: begin
          r2_r    <= r2_r + R2_W'(prod_r[SQ_W-1:0]);
          dz2_r   <= prod_r[SQ_W-1:0];
          state_r <= S_CLO;
        end
        S_CLO: begin
          in_sphere_r <= (r2_r < R2_W'(h2_r));
          prod_r      <= unsigned'(mul_p);
          state_r     <= S_CHI;
        end
        S_CHI: begin
          cone_lo_r <= prod_r;
          prod_r    <= unsigned'(mul_p);
          state_r   <= S_CMP;
        end
        S_CMP: begin
          cone_hit_r <= in_sphere_r && (r2_r != '0) && (cone_lhs >= cone_rhs);
          state_r    <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            if (item_r.last_nbr) begin
              out_valid_r                <= 1'b1;
              out_data_r.neighbor_count  <= count_nxt;
              out_data_r.cone_mass       <= mass_nxt;
              out_data_r.saturated       <= sat_nxt;
              count_total_r              <= '0;
              mass_total_r               <= '0;
              sat_r                      <= 1'b0;
            end else begin
              count_total_r <= count_nxt;
              mass_total_r  <= mass_nxt;
              sat_r         <= sat_nxt;
            end
            in_sphere_r <= 1'b0;
            cone_hit_r  <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_xfer_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_RAD))
    else $error("transfer did not start the sequencer");

  a_cone_in_sphere: assert property (@(posedge clk) disable iff (!rst_n)
    cone_hit_r |-> in_sphere_r)
    else $error("cone hit outside the sphere");

  a_totals_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && fin_go && item_r.last_nbr) |=>
      (count_total_r == '0 && mass_total_r == '0 && !sat_r && out_valid_r))
    else $error("totals not cleared after result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && !(state_r == S_FIN)) |=> out_valid_r)
    else $error("pending result dropped");

endmodule
